[rtl/signed_radix_digit_formatter_macros.svh]
// assertion macros for the port-level formatter checker
`ifndef SIGNED_RADIX_DIGIT_FORMATTER_MACROS_SVH
`define SIGNED_RADIX_DIGIT_FORMATTER_MACROS_SVH

// same-cycle implication, checked on the rising edge outside reset
`define SRDF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising edge outside reset
`define SRDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/srdf_pkg.sv]
// shared types and constants of the signed radix digit formatter
package srdf_pkg;

    // character codes
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;

    // field and register widths
    localparam int SYMBOL_W   = 8;
    localparam int DIGIT_W    = 4;
    localparam int BASE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ALPHA_SYMS = 16;

    // quotient bits resolved per divider cycle
    localparam int STEP_BITS = 4;

    // smallest usable radix
    localparam logic [BASE_W-1:0] MIN_RADIX = 5'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LENGTH   = 2'd0,
        CFG_ALPHABET_LOW  = 2'd1,
        CFG_ALPHABET_HIGH = 2'd2
    } t_cfg_index;

endpackage

[rtl/srdf_div_step.sv]
// shared divider slice: several restoring steps of division by a small radix
module srdf_div_step (
    input  logic [srdf_pkg::DIGIT_W-1:0]   i_rem,
    input  logic [srdf_pkg::STEP_BITS-1:0] i_bits,
    input  logic [srdf_pkg::BASE_W-1:0]    i_radix,
    output logic [srdf_pkg::DIGIT_W-1:0]   o_rem,
    output logic [srdf_pkg::STEP_BITS-1:0] o_quot
);
    import srdf_pkg::*;

    logic [BASE_W-1:0]  w_acc;
    logic [DIGIT_W-1:0] w_rem;

    // shift one dividend bit into the remainder, subtract radix when it fits
    always_comb begin
        w_rem  = i_rem;
        w_acc  = '0;
        o_quot = '0;
        for (int b = STEP_BITS - 1; b >= 0; b--) begin
            w_acc = {w_rem, i_bits[b]};
            if (w_acc >= i_radix) begin
                o_quot[b] = 1'b1;
                w_acc     = w_acc - i_radix;
            end
            w_rem = w_acc[DIGIT_W-1:0];
        end
        o_rem = w_rem;
    end

endmodule

[rtl/signed_radix_digit_formatter.sv]
// top level: signed integer to text in a configured radix and alphabet
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_value
//  out     | out       | o_out_valid / i_out_stall  | o_symbol, o_last_symbol
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one value at a time: an alphabet scan of the base_length symbols in use, then one
// shared divider slice at STEP_BITS quotient bits a cycle, then one symbol at a time.
// o_in_stall is high from acceptance until the last symbol is loaded for output or the
// scan finds a bad alphabet; a value taken with an unusable radix never raises it.
// synchronous active-low reset clears control state and all three registers.
// output stalls hold the current symbol and pause the pop sequence.
module signed_radix_digit_formatter #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [VALUE_BITS-1:0]       i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [srdf_pkg::SYMBOL_W-1:0]      o_symbol,
    output logic                               o_last_symbol,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [srdf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [srdf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srdf_pkg::*;

    localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = STEPS * STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int COUNT_W    = $clog2(VALUE_BITS + 1);
    localparam int STACK_W    = VALUE_BITS * DIGIT_W;
    localparam int ALPHA_W    = ALPHA_SYMS * SYMBOL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_POP
    } t_state;

    t_state                  r_state;
    logic [BASE_W-1:0]       r_base_length;
    logic [CFG_DATA_W-1:0]   r_alpha_low;
    logic [CFG_DATA_W-1:0]   r_alpha_high;
    logic                    r_neg;
    logic [PAD_BITS-1:0]     r_work;
    logic [DIGIT_W-1:0]      r_rem;
    logic [STEP_CNT_W-1:0]   r_step;
    logic [DIGIT_W-1:0]      r_idx;
    logic [STACK_W-1:0]      r_stack;
    logic [COUNT_W-1:0]      r_count;
    logic                    r_out_valid;
    logic [SYMBOL_W-1:0]     r_symbol;
    logic                    r_last;

    logic [ALPHA_W-1:0]      w_alpha;
    logic [VALUE_BITS-1:0]   w_mag;
    logic                    w_radix_ok;
    logic [SYMBOL_W-1:0]     w_sym_i;
    logic                    w_bad;
    logic                    w_idx_last;
    logic [DIGIT_W-1:0]      w_rem_next;
    logic [STEP_BITS-1:0]    w_qbits;
    logic [PAD_BITS-1:0]     w_work_next;
    logic                    w_out_free;

    assign w_alpha     = {r_alpha_high, r_alpha_low};
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last_symbol = r_last;
    assign o_cfg_ready = 1'b1;

    // magnitude in unsigned form, most negative value included
    assign w_mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    assign w_radix_ok = (r_base_length >= MIN_RADIX)
                     && (r_base_length <= BASE_W'(MAX_BASE));

    // alphabet scan: symbol r_idx against sign codes and every later symbol in use
    assign w_sym_i    = w_alpha[r_idx*SYMBOL_W +: SYMBOL_W];
    assign w_idx_last = (({1'b0, r_idx} + 1'b1) == r_base_length);

    always_comb begin
        w_bad = (w_sym_i == SYM_PLUS) || (w_sym_i == SYM_MINUS);
        for (int j = 0; j < ALPHA_SYMS; j++) begin
            if ((DIGIT_W'(j) > r_idx) && (BASE_W'(j) < r_base_length)
                    && (w_alpha[j*SYMBOL_W +: SYMBOL_W] == w_sym_i)) begin
                w_bad = 1'b1;
            end
        end
    end

    // shared divider slice
    srdf_div_step u_div (
        .i_rem   (r_rem),
        .i_bits  (r_work[PAD_BITS-1 -: STEP_BITS]),
        .i_radix (r_base_length),
        .o_rem   (w_rem_next),
        .o_quot  (w_qbits)
    );

    assign w_work_next = {r_work[PAD_BITS-STEP_BITS-1:0], w_qbits};

    // sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_base_length <= '0;
            r_alpha_low   <= '0;
            r_alpha_high  <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BASE_LENGTH:   r_base_length <= i_cfg_data[BASE_W-1:0];
                    CFG_ALPHABET_LOW:  r_alpha_low   <= i_cfg_data;
                    CFG_ALPHABET_HIGH: r_alpha_high  <= i_cfg_data;
                    default: ;
                endcase
            end

            // taken beat empties the output unless a new symbol is loaded below
            if (w_out_free && (r_state != S_SIGN) && (r_state != S_POP)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_neg  <= i_value[VALUE_BITS-1];
                        r_work <= PAD_BITS'(w_mag);
                        r_idx  <= '0;
                        if (w_radix_ok) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_bad) begin
                        r_state <= S_IDLE;
                    end else if (w_idx_last) begin
                        r_state <= S_DIV;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_count <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    r_work <= w_work_next;
                    // digit complete: push remainder, stop on zero quotient
                    if (r_step == STEP_CNT_W'(STEPS - 1)) begin
                        r_step  <= '0;
                        r_rem   <= '0;
                        r_stack <= {r_stack[STACK_W-DIGIT_W-1:0], w_rem_next};
                        r_count <= r_count + 1'b1;
                        if (w_work_next == '0) begin
                            r_state <= r_neg ? S_SIGN : S_POP;
                        end
                    end else begin
                        r_rem  <= w_rem_next;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_symbol    <= SYM_MINUS;
                        r_last      <= (r_count == '0);
                        r_state     <= S_POP;
                    end
                end
                S_POP: begin
                    // most significant digit sits at the bottom of the stack
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_symbol    <= w_alpha[r_stack[DIGIT_W-1:0]*SYMBOL_W +: SYMBOL_W];
                        r_last      <= (r_count == COUNT_W'(1));
                        r_stack     <= {DIGIT_W'(0), r_stack[STACK_W-1:DIGIT_W]};
                        r_count     <= r_count - 1'b1;
                        if (r_count == COUNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/srdf_checker.sv]
// port-level checker for the formatter, bound to the top level
`include "signed_radix_digit_formatter_macros.svh"

module srdf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [srdf_pkg::SYMBOL_W-1:0] o_symbol,
    input logic                          o_last_symbol
);
    import srdf_pkg::*;

    // a stalled output beat stays offered
    `SRDF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output beat dropped under stall")

    // a stalled output beat keeps its payload
    `SRDF_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_symbol) && $stable(o_last_symbol), "stalled payload changed")

    // a minus sign always has digits after it
    `SRDF_ASSERT_IMPL(a_minus_not_last, o_out_valid && (o_symbol == SYM_MINUS), !o_last_symbol, "minus sign marked last")

    // a plus sign can never come out of a valid alphabet
    `SRDF_ASSERT_IMPL(a_no_plus, o_out_valid, o_symbol != SYM_PLUS, "plus sign emitted")

    // no new value is taken while a text is still being sent
    `SRDF_ASSERT_IMPL(a_busy_mid_text, o_out_valid && !i_out_stall && !o_last_symbol, o_in_stall, "input open in mid text")

endmodule

bind signed_radix_digit_formatter srdf_checker u_srdf_checker (.*);

[sim/srdf_text_checker.sv]
// checker for the radix formatter: mirrors the registers, predicts each text and compares
`timescale 1ns / 1ps

module srdf_text_checker
    import srdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic signed [31:0]    i_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [SYMBOL_W-1:0]   i_symbol,
    input  logic                  i_last_symbol,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_values,
    output int                    o_symbols
);

    localparam int RADIX_MAX = 16;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last_symbol;
    } t_text_beat;

    // mirrored register state
    logic [BASE_W-1:0]     fmt_radix;
    logic [CFG_DATA_W-1:0] fmt_low;
    logic [CFG_DATA_W-1:0] fmt_high;

    t_text_beat text_q[$];

    // digit symbol k of the configured alphabet
    function automatic logic [7:0] glyph(input int k);
        logic [63:0] w;
        w = (k < 8) ? fmt_low : fmt_high;
        return w[(k % 8) * 8 +: 8];
    endfunction

    // no sign characters and no repeats among the symbols in use
    function automatic bit alphabet_clean(input int radix);
        logic [7:0] a;
        for (int i = 0; i < radix; i++) begin
            a = glyph(i);
            if (a == SYM_PLUS || a == SYM_MINUS)
                return 1'b0;
            for (int j = i + 1; j < radix; j++)
                if (a == glyph(j))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // queue the symbols that one value turns into
    function automatic void format_value(input logic [31:0] v);
        int unsigned radix;
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  digits [32];
        int          cnt;
        radix = 32'(fmt_radix);
        if (radix < 2 || radix > RADIX_MAX || !alphabet_clean(radix))
            return;
        neg = v[31];
        // unsigned negate keeps the most negative value exact
        mag = neg ? (32'd0 - v) : v;
        cnt = 0;
        do begin
            digits[cnt] = 4'(mag % radix);
            cnt++;
            mag = mag / radix;
        end while (mag != 0);
        if (neg)
            text_q.push_back('{symbol: SYM_MINUS, last_symbol: 1'b0});
        for (int k = cnt - 1; k >= 0; k--)
            text_q.push_back('{symbol: glyph(digits[k]), last_symbol: (k == 0)});
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("checker: %s: got %h want %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_values     = 0;
        o_symbols    = 0;
        fmt_radix    = '0;
        fmt_low      = '0;
        fmt_high     = '0;
    end

    // watch all three channels on the rising edge
    always @(posedge i_clk) begin
        t_text_beat want;
        if (!i_rst_n) begin
            fmt_radix = '0;
            fmt_low   = '0;
            fmt_high  = '0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE_LENGTH:   fmt_radix = i_cfg_data[BASE_W-1:0];
                    CFG_ALPHABET_LOW:  fmt_low   = i_cfg_data;
                    CFG_ALPHABET_HIGH: fmt_high  = i_cfg_data;
                    default: ;
                endcase
            end
            // output beats against the oldest expected symbol
            if (i_out_valid && !i_out_stall) begin
                o_symbols++;
                if (text_q.size() == 0) begin
                    report_mismatch("symbol with nothing pending", i_symbol, 8'h00);
                end else begin
                    want = text_q.pop_front();
                    if (i_symbol !== want.symbol)
                        report_mismatch("symbol", i_symbol, want.symbol);
                    if (i_last_symbol !== want.last_symbol)
                        report_mismatch("last flag", {7'd0, i_last_symbol},
                                        {7'd0, want.last_symbol});
                end
            end
            // input beats
            if (i_in_valid && !i_in_stall) begin
                o_values++;
                format_value(i_value);
            end
            o_pending = text_q.size();
        end
    end

endmodule

[sim/tb.sv]
// testbench top for the radix formatter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import srdf_pkg::*;

    localparam int           RANDOM_VALUES  = 100;
    localparam int           SETTLE_CYCLES  = 320;
    localparam int           HOLD_CYCLES    = 600;
    localparam logic [1:0]   CFG_INDEX_NONE = 2'd3;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic signed [31:0]    in_value    = '0;
    logic                  sink_stall  = 1'b1;
    logic                  hold_off    = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall;
    logic [SYMBOL_W-1:0]   symbol;
    logic                  last_symbol;
    logic                  cfg_ready;
    int                    fail_count;
    int                    pending;
    int                    values_seen;
    int                    symbols_seen;
    bit                    quiet       = 1'b0;
    bit                    hold_go     = 1'b0;
    int                    settings    = 0;

    assign out_stall = sink_stall | hold_off;

    signed_radix_digit_formatter dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_value       (in_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_symbol      (symbol),
        .o_last_symbol (last_symbol),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    srdf_text_checker u_text_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_value       (in_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_symbol      (symbol),
        .i_last_symbol (last_symbol),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_values      (values_seen),
        .o_symbols     (symbols_seen)
    );

    // 10 ns clock
    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    // symbol sink with random stall before each beat
    initial begin : sink
        int gap;
        @(negedge clk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                sink_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            sink_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    // one long hold-off on the output so the input backs up
    initial begin
        wait (hold_go);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // offer one value, called and returning on a falling edge
    task automatic push_value(input logic signed [31:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // one register write beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // let the block drain, including values that produced no text
    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // program radix and alphabet, in random order
    task automatic load_format(input logic [63:0] base_word, input logic [127:0] alpha);
        settle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_BASE_LENGTH, base_word);
            write_reg(CFG_ALPHABET_LOW, alpha[63:0]);
            write_reg(CFG_ALPHABET_HIGH, alpha[127:64]);
        end else begin
            write_reg(CFG_ALPHABET_HIGH, alpha[127:64]);
            write_reg(CFG_ALPHABET_LOW, alpha[63:0]);
            write_reg(CFG_BASE_LENGTH, base_word);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_NONE, {$urandom, $urandom});
        settings++;
    endtask

    // distinct non-sign symbols in use, anything at all in the unused bytes
    function automatic logic [127:0] draw_alphabet(input int radix);
        logic [127:0] alpha;
        logic [7:0]   b;
        bit           clash;
        alpha = '0;
        for (int k = 0; k < 16; k++) begin
            if (k < radix) begin
                do begin
                    b = 8'($urandom_range(0, 255));
                    clash = (b == SYM_PLUS) || (b == SYM_MINUS);
                    for (int j = 0; j < k; j++)
                        if (alpha[j*8 +: 8] == b)
                            clash = 1'b1;
                end while (clash);
            end else begin
                b = ($urandom_range(0, 3) == 0) ? SYM_MINUS : 8'($urandom_range(0, 255));
            end
            alpha[k*8 +: 8] = b;
        end
        return alpha;
    endfunction

    // value mix: full range, small, extremes, shortened
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5: v = $signed($urandom_range(0, 600)) - 300;
            6: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 32'sh0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            default: v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    // stimulus and verdict
    initial begin : stimulus
        int               radix;
        int               kind;
        int               n_items;
        int               i;
        int               j;
        int               pos;
        int               random_values;
        bit               cfg_ok;
        bit               hold_done;
        logic [63:0]      base_word;
        logic [127:0]     alpha;
        random_values = 0;
        hold_done     = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: radix zero, nothing comes out
        push_value(32'sd5);

        // radix 2, sign characters parked in the unused bytes
        load_format(64'd2, {{7{16'h2B2D}}, "10"});
        write_reg(CFG_INDEX_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_value(32'sd0);
        push_value(32'sd1);
        push_value(-32'sd1);
        push_value(32'sh7FFF_FFFF);
        push_value(32'sh8000_0000);

        // radix 16, full alphabet
        load_format(64'd16, "FEDCBA9876543210");
        push_value(32'sh8000_0000);
        push_value(32'sh7FFF_FFFF);
        push_value(-32'sd1);
        push_value(32'shDEAD_BEEF);

        // radix 10 with a zero byte as digit zero
        load_format(64'd10, {48'h2B2D_2B2D_2B2D, "987654321", 8'h00});
        push_value(32'sd0);
        push_value(32'sh8000_0000);
        push_value(32'sd1234567890);

        // radix 3 from a write with garbage above the field
        load_format(64'hFFFF_FFFF_FFFF_FFE3, {{13{8'h2D}}, "ZYX"});
        push_value(-32'sd7);

        // radix below 2 and above the alphabet size
        load_format(64'd1, "FEDCBA9876543210");
        push_value(32'sd9);
        load_format(64'hFFFF_FFFF_FFFF_FFF1, "FEDCBA9876543210");
        push_value(32'sd9);

        // repeated symbol, plus in the last position, minus in the first
        load_format(64'd4, {96'h0, "ABCB"});
        push_value(32'sd3);
        load_format(64'd16, "+EDCBA9876543210");
        push_value(32'sd3);
        load_format(64'd5, {88'h0, "abcd-"});
        push_value(32'sd3);

        // random register settings, each with a run of values
        while (random_values < RANDOM_VALUES) begin
            kind   = $urandom_range(0, 9);
            radix  = $urandom_range(2, 16);
            alpha  = draw_alphabet(radix);
            cfg_ok = 1'b1;
            if (kind == 0) begin
                radix = $urandom_range(0, 16);
                if (radix >= 2)
                    radix = radix + 15;
                cfg_ok = 1'b0;
            end else if (kind == 1) begin
                i = $urandom_range(0, radix - 2);
                j = $urandom_range(i + 1, radix - 1);
                alpha[j*8 +: 8] = alpha[i*8 +: 8];
                cfg_ok = 1'b0;
            end else if (kind == 2) begin
                pos = $urandom_range(0, 1) ? radix - 1 : $urandom_range(0, radix - 1);
                alpha[pos*8 +: 8] = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
                cfg_ok = 1'b0;
            end
            base_word = {$urandom, $urandom};
            base_word[BASE_W-1:0] = radix[BASE_W-1:0];
            load_format(base_word, alpha);
            quiet = ($urandom_range(0, 4) == 0);
            if (cfg_ok && !hold_done) begin
                hold_go   = 1'b1;
                hold_done = 1'b1;
                quiet     = 1'b0;
            end
            n_items = cfg_ok ? $urandom_range(4, 14) : $urandom_range(1, 3);
            repeat (n_items) begin
                push_value(pick_value());
                if (cfg_ok)
                    random_values++;
            end
        end

        // drain and report
        in_valid <= 1'b0;
        quiet = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("summary: %0d values formatted into %0d checked symbols", values_seen,
                 symbols_seen);
        $display("summary: %0d register settings, radix 0 to 31 with bad alphabets",
                 settings);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
